// ----- hdl/aes_pkg.sv -----
`default_nettype none
package aes_pkg;

    localparam int ROUNDS_DEF = 14;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_A    = 3'd0,
        REG_KEY_B    = 3'd1,
        REG_KEY_C    = 3'd2,
        REG_KEY_D    = 3'd3,
        REG_NONCE_HI = 3'd4,
        REG_NONCE_LO = 3'd5,
        REG_XOR_MODE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic load_key;
        logic key_step;
        logic load_ctr;
        logic blk_start;
        logic blk_round;
        logic blk_final;
    } aes_cmd_t;

    typedef struct packed {
        logic key_last;
    } aes_sts_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/aes_ram.sv -----
`default_nettype none
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/aes_datapath.sv -----
`default_nettype none
module aes_datapath
    import aes_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire aes_cmd_t      cmd,
    output aes_sts_t           sts,
    input  wire logic [255:0]  key,
    input  wire logic [127:0]  nonce,
    input  wire logic [3:0]    byte_pos,
    output logic      [7:0]    ks_byte
);
    localparam int RK_WORDS = 4 * (ROUNDS + 1);
    localparam int RKR = ROUNDS + 1;
    localparam int RA_W = $clog2(RKR);

    // Key window: last eight round key words, newest in low bits.
    logic [255:0] win_reg, win_next;
    logic [$clog2(RK_WORDS+1)-1:0] kidx_reg;
    logic [7:0] rcon_reg;
    logic [127:0] ctr_reg;
    logic [127:0] st_reg, st_next;
    logic [RA_W-1:0] rd_round_reg;
    logic [RA_W-1:0] rd_next;
    logic [127:0] rk_rdata;
    logic [127:0] ks_reg;

    // Write round keys four words (one round) at a time.
    logic rk_we;
    logic [RA_W-1:0] rk_waddr;
    logic [31:0] t_w, nw;
    logic [2:0] kmod;

    assign kmod = kidx_reg[2:0];

    always_comb begin
        t_w = win_reg[31:0];
        if (kmod == 3'd0) begin
            t_w = sub_word({t_w[23:0], t_w[31:24]}) ^ {rcon_reg, 24'd0};
        end else if (kmod == 3'd4) begin
            t_w = sub_word(t_w);
        end
        nw = win_reg[255:224] ^ t_w;
        win_next = {win_reg[223:0], nw};
    end

    // After word index k is formed (k = 3 mod 4), the low four words are a round.
    assign rk_we    = cmd.key_step && (kidx_reg[1:0] == 2'd3);
    assign rk_waddr = RA_W'(kidx_reg >> 2);

    // Words 0..7 are written in two extra steps of load phase below.
    logic ld_we;
    logic [RA_W-1:0] ld_addr;
    logic [127:0] ld_data;
    logic ld_phase_reg;

    assign ld_we   = cmd.load_key || ld_phase_reg;
    assign ld_addr = cmd.load_key ? RA_W'(0) : RA_W'(1);
    assign ld_data = cmd.load_key ? key[255:128] : win_reg[127:0];

    logic ram_we;
    logic [RA_W-1:0] ram_waddr;
    logic [127:0] ram_wdata;

    assign ram_we    = ld_we || rk_we;
    assign ram_waddr = ld_we ? ld_addr : rk_waddr;
    assign ram_wdata = ld_we ? ld_data : {win_reg[95:0], nw};

    // Address the next round so the registered read lines up with the state.
    assign rd_next = (cmd.blk_start || (cmd.blk_round && !cmd.blk_final)) ?
                     rd_round_reg + 1'b1 : '0;

    aes_ram #(.WIDTH(128), .DEPTH(RKR)) u_rk (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_next),
        .rdata (rk_rdata)
    );

    assign sts.key_last = (kidx_reg == ($bits(kidx_reg))'(RK_WORDS - 1));

    // Round function on the state, column-major bytes, byte 0 in high bits.
    logic [7:0] sb [16];
    logic [7:0] sr [16];
    logic [7:0] mc [16];
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[i] = st_reg[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr[4*c+r] = sbox(sb[4*((c+r)%4)+r]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sr[4*c]; a1 = sr[4*c+1]; a2 = sr[4*c+2]; a3 = sr[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            mc[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            mc[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            mc[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        st_next = st_reg;
        if (cmd.blk_start) begin
            st_next = ctr_reg ^ rk_rdata;
        end else if (cmd.blk_round) begin
            for (int i = 0; i < 16; i++) begin
                st_next[127-8*i -: 8] = (cmd.blk_final ? sr[i] : mc[i]);
            end
            st_next = st_next ^ rk_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg      <= '0;
            kidx_reg     <= '0;
            rcon_reg     <= 8'h01;
            ld_phase_reg <= 1'b0;
            rd_round_reg <= '0;
        end else begin
            ld_phase_reg <= cmd.load_key;
            if (cmd.load_key) begin
                win_reg  <= key;
                kidx_reg <= ($bits(kidx_reg))'(8);
                rcon_reg <= 8'h01;
            end else if (cmd.key_step) begin
                win_reg  <= win_next;
                kidx_reg <= kidx_reg + 1'b1;
                if (kmod == 3'd0) begin
                    rcon_reg <= xtime(rcon_reg);
                end
            end
            if (cmd.load_ctr) begin
                ctr_reg <= nonce;
            end
            if (cmd.blk_start || cmd.blk_round) begin
                st_reg <= st_next;
            end
            rd_round_reg <= rd_next;
            if (cmd.blk_round && cmd.blk_final) begin
                ctr_reg <= ctr_reg + 128'd1;
                ks_reg  <= st_next;
            end
        end
    end

    assign ks_byte = ks_reg[127-8*byte_pos -: 8];
endmodule
`default_nettype wire

// ----- hdl/aes_ctrl.sv -----
`default_nettype none
module aes_ctrl
    import aes_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic       in_first,
    input  wire logic       m_busy,
    output logic            take_out,
    output logic [3:0]      byte_pos,
    output aes_cmd_t        cmd,
    input  wire aes_sts_t   sts
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_KEYLD, ST_KEY, ST_PRIME, ST_RND, ST_OUT
    } state_t;

    state_t state_reg;
    logic [3:0] pos_reg;
    logic [$clog2(ROUNDS+1)-1:0] rnd_reg;

    assign s_tready = (state_reg == ST_IDLE) && !m_busy;
    assign byte_pos = pos_reg;

    always_comb begin
        cmd = '0;
        cmd.load_key  = (state_reg == ST_IDLE) && s_tvalid && s_tready && in_first;
        cmd.load_ctr  = cmd.load_key;
        cmd.key_step  = (state_reg == ST_KEY);
        cmd.blk_start = (state_reg == ST_PRIME);
        cmd.blk_round = (state_reg == ST_RND);
        cmd.blk_final = (state_reg == ST_RND) &&
                        (rnd_reg == ($bits(rnd_reg))'(ROUNDS));
        take_out = (state_reg == ST_OUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            rnd_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        if (in_first) begin
                            pos_reg   <= '0;
                            state_reg <= ST_KEYLD;
                        end else if (pos_reg == 4'd0) begin
                            state_reg <= ST_PRIME;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_KEYLD: state_reg <= ST_KEY;
                ST_KEY: begin
                    if (sts.key_last) begin
                        state_reg <= ST_PRIME;
                    end
                end
                ST_PRIME: begin
                    rnd_reg   <= ($bits(rnd_reg))'(1);
                    state_reg <= ST_RND;
                end
                ST_RND: begin
                    rnd_reg <= rnd_reg + 1'b1;
                    if (cmd.blk_final) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    pos_reg   <= pos_reg + 4'd1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.blk_final |-> state_reg == ST_RND)
        else $error("final round outside round state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        take_out |=> pos_reg == $past(pos_reg) + 4'd1)
        else $error("position did not advance");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_key |=> state_reg == ST_KEYLD)
        else $error("key load without expansion");
endmodule
`default_nettype wire

// ----- hdl/aes256_ctr_stream.sv -----
`default_nettype none
// Path from accept to m_tvalid: a byte flagged first passes key load, key expansion,
// whitening, the rounds and output; a byte that starts a keystream block passes
// whitening, the rounds and output; any other byte goes straight to output.
// A new byte is accepted only once the previous one has been output; a stalled
// m_tready holds the input.
// Reset: synchronous active-low aresetn clears control, counter, config
// registers (xor_mode to 1); round key memory is not cleared.
module aes256_ctr_stream
    import aes_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // data_byte
    input  wire logic                 s_tuser,   // first
    input  wire logic                 s_tlast,   // last_in
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [7:0]           m_tdata,   // out_byte
    output logic                      m_tlast,   // last_out
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);
    logic [255:0] key_reg;
    logic [127:0] nonce_reg;
    logic xor_reg;
    logic [7:0] data_reg;
    logic last_reg;
    logic take_out;
    logic [3:0] byte_pos;
    logic [7:0] ks_byte;
    aes_cmd_t cmd;
    aes_sts_t sts;

    assign cfg_ready = 1'b1;

    aes_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_first (s_tuser),
        .m_busy   (m_tvalid && !m_tready),
        .take_out (take_out),
        .byte_pos (byte_pos),
        .cmd      (cmd),
        .sts      (sts)
    );

    aes_datapath #(.ROUNDS(ROUNDS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .key      (key_reg),
        .nonce    (nonce_reg),
        .byte_pos (byte_pos),
        .ks_byte  (ks_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            nonce_reg <= '0;
            xor_reg   <= 1'b1;
            m_tvalid  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_reg_t'(cfg_index))
                    REG_KEY_A:    key_reg[255:192] <= cfg_data;
                    REG_KEY_B:    key_reg[191:128] <= cfg_data;
                    REG_KEY_C:    key_reg[127:64]  <= cfg_data;
                    REG_KEY_D:    key_reg[63:0]    <= cfg_data;
                    REG_NONCE_HI: nonce_reg[127:64] <= cfg_data;
                    REG_NONCE_LO: nonce_reg[63:0]   <= cfg_data;
                    REG_XOR_MODE: xor_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                data_reg <= s_tdata;
                last_reg <= s_tlast;
            end
            if (take_out) begin
                m_tvalid <= 1'b1;
                m_tdata  <= xor_reg ? (ks_byte ^ data_reg) : ks_byte;
                m_tlast  <= last_reg;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sim/aes256_ctr_stream_tb.sv -----
`timescale 1ns / 1ps
module aes256_ctr_stream_tb;
    import aes_pkg::*;

    class ctr_keystream_scoreboard;
        logic [63:0] key_reg [4];
        logic [63:0] nonce_hi;
        logic [63:0] nonce_lo;
        logic        xor_en;
        logic [31:0] rk [60];
        logic [127:0] ctr;
        logic [7:0]  ks [16];
        int unsigned pos;
        logic [8:0]  pending [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned blocks;

        function new();
            foreach (key_reg[i]) key_reg[i] = '0;
            nonce_hi = '0;
            nonce_lo = '0;
            xor_en = 1'b1;
            ctr = '0;
            pos = 0;
            errors = 0;
            checked = 0;
            blocks = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [63:0] val);
            case (idx)
                REG_KEY_A:    key_reg[0] = val;
                REG_KEY_B:    key_reg[1] = val;
                REG_KEY_C:    key_reg[2] = val;
                REG_KEY_D:    key_reg[3] = val;
                REG_NONCE_HI: nonce_hi = val;
                REG_NONCE_LO: nonce_lo = val;
                REG_XOR_MODE: xor_en = val[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] sb(logic [7:0] a);
            logic [7:0] inv;
            logic [7:0] x;
            logic [7:0] p;
            logic [7:0] q;
            int k;
            inv = 8'h00;
            if (a != 8'h00) begin
                // a^254 in GF(2^8)
                p = a;
                inv = 8'h01;
                for (k = 0; k < 8; k++) begin
                    if (k != 0) inv = gmul(inv, p);
                    p = gmul(p, p);
                end
            end
            x = inv;
            q = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]};
            return q ^ 8'h63;
        endfunction

        function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
            logic [7:0] r;
            int k;
            r = 8'h00;
            for (k = 0; k < 8; k++) begin
                if (b[k]) r = r ^ a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            end
            return r;
        endfunction

        function logic [31:0] sw(logic [31:0] w);
            return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
        endfunction

        function void expand();
            logic [31:0] t;
            logic [7:0]  rc;
            int i;
            rc = 8'h01;
            for (i = 0; i < 8; i++) rk[i] = 32'(key_reg[i / 2] >> ((i % 2) ? 0 : 32));
            for (i = 8; i < 60; i++) begin
                t = rk[i - 1];
                if (i % 8 == 0) begin
                    t = sw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = gmul(rc, 8'h02);
                end else if (i % 8 == 4) begin
                    t = sw(t);
                end
                rk[i] = rk[i - 8] ^ t;
            end
        endfunction

        function void encrypt();
            logic [7:0] s [16];
            logic [7:0] t [16];
            logic [7:0] a0, a1, a2, a3, al;
            int i, c, r, rd;
            for (i = 0; i < 16; i++) s[i] = 8'(ctr >> (120 - 8 * i));
            for (rd = 0; rd <= 14; rd++) begin
                if (rd != 0) begin
                    for (c = 0; c < 4; c++)
                        for (r = 0; r < 4; r++) t[4 * c + r] = sb(s[4 * ((c + r) % 4) + r]);
                    if (rd != 14) begin
                        for (c = 0; c < 4; c++) begin
                            a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                            al = a0 ^ a1 ^ a2 ^ a3;
                            t[4 * c]     = a0 ^ al ^ gmul(a0 ^ a1, 8'h02);
                            t[4 * c + 1] = a1 ^ al ^ gmul(a1 ^ a2, 8'h02);
                            t[4 * c + 2] = a2 ^ al ^ gmul(a2 ^ a3, 8'h02);
                            t[4 * c + 3] = a3 ^ al ^ gmul(a3 ^ a0, 8'h02);
                        end
                    end
                    s = t;
                end
                for (c = 0; c < 4; c++)
                    for (r = 0; r < 4; r++)
                        s[4 * c + r] ^= 8'(rk[4 * rd + c] >> (24 - 8 * r));
            end
            ks = s;
            blocks++;
        endfunction

        function void note_input(logic [7:0] d, logic fst, logic lst);
            logic [7:0] o;
            if (fst) begin
                expand();
                ctr = {nonce_hi, nonce_lo};
                pos = 0;
            end
            if (pos == 0) begin
                encrypt();
                ctr = ctr + 128'd1;
            end
            o = xor_en ? (ks[pos] ^ d) : ks[pos];
            pending.push_back({lst, o});
            pos = (pos + 1) % 16;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [7:0] d, logic lst);
            logic [8:0] e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected byte %02h", d));
            end else begin
                e = pending.pop_front();
                checked++;
                if (d !== e[7:0]) report($sformatf("byte %02h, want %02h", d, e[7:0]));
                if (lst !== e[8]) report($sformatf("tlast %b, want %b", lst, e[8]));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    ctr_keystream_scoreboard sbd = new();
    bit calm = 1'b0;
    int unsigned bytes_sent = 0;

    always #5 aclk = ~aclk;

    aes256_ctr_stream u_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sbd.check_result(m_tdata, m_tlast);
        m_tready <= calm || ($urandom_range(99) >= 18);
    end

    task write_reg(cfg_reg_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sbd.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task send_byte(logic [7:0] d, logic fst, logic lst);
        while (!calm && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= fst;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sbd.note_input(d, fst, lst);
        bytes_sent++;
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (sbd.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task send_message(int n);
        int i;
        for (i = 0; i < n; i++) send_byte(8'($urandom), i == 0, i == n - 1);
    endtask

    task program_all(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
                     logic [63:0] nh, logic [63:0] nl, logic xm);
        write_reg(REG_KEY_A, k0);
        write_reg(REG_KEY_B, k1);
        write_reg(REG_KEY_C, k2);
        write_reg(REG_KEY_D, k3);
        write_reg(REG_NONCE_HI, nh);
        write_reg(REG_NONCE_LO, nl);
        write_reg(REG_XOR_MODE, {63'd0, xm});
    endtask

    initial begin
        int i;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero key, extremes of data, flag combinations
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'haa, 1'b1, 1'b1);
        send_byte(8'h0f, 1'b0, 1'b0);
        drain();
        program_all('1, '1, '1, '1, '1, 64'hffff_ffff_ffff_fffe, 1'b0);
        for (i = 0; i < 18; i++) send_byte(8'($urandom), i == 0, i == 17);
        drain();
        // nonce written mid-stream waits for the next restart; xor mode applies at once
        write_reg(REG_XOR_MODE, 64'd1);
        write_reg(REG_NONCE_HI, 64'h0123_4567_89ab_cdef);
        send_byte(8'h3c, 1'b0, 1'b1);
        drain();

        for (i = 0; i < 12; i++) begin
            program_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, (i == 3) ? '1 : {$urandom, $urandom},
                        (i == 3) ? 64'hffff_ffff_ffff_fff0 : {$urandom, $urandom},
                        i % 3 != 0);
            calm = (i == 5);
            repeat ($urandom_range(1, 3)) send_message($urandom_range(1, 32));
            if ($urandom_range(3) == 0) send_byte(8'($urandom), 1'b0, 1'($urandom));
            drain();
        end
        calm = 1'b0;
        program_all('0, '0, '0, '0, '0, '0, 1'b1);
        send_message(20);
        drain();
        $display("covered %0d bytes, %0d keystream blocks, %0d results checked",
                 bytes_sent, sbd.blocks, sbd.checked);
        $display("key/nonce extremes, both modes, counter wrap, stalls on both sides");
        if (sbd.errors == 0 && sbd.pending.size() == 0) begin
            $display("aes256_ctr_stream regression: pass");
        end else begin
            $display("aes256_ctr_stream regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("aes256_ctr_stream regression: fail");
        $finish;
    end
endmodule
